// File: hw/rtl/hsl2argb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2argb_pkg
// Shared constants, widths and types of the HSL to ARGB8888 converter.
// ----------------------------------------------------------------------------
package hsl2argb_pkg;

  localparam int HueFracBits   = 6;
  localparam int LevelFracBits = 8;

  localparam int HueWidth   = 15;
  localparam int LevelWidth = 9;
  localparam int AlphaWidth = 8;
  localparam int RgbWidth   = 24;

  localparam int LevelOne  = 1 << LevelFracBits;
  localparam int HueSector = 60 << HueFracBits;
  localparam int HueFull   = 6 * HueSector;
  localparam int MidBias   = HueSector / 2;

  localparam int TposWidth = $clog2(2 * HueSector);
  localparam int TWidth    = $clog2(HueSector + 1);
  localparam int CnumWidth = 2 * LevelFracBits + 1;
  localparam int ProdWidth = CnumWidth + TWidth - 1;
  localparam int AccWidth  = ProdWidth + 1;

  // Channel scale: floor(acc * 255 / (LevelOne^2 * HueSector)) done as a
  // constant multiply and a right shift.
  localparam int ScaleShift = 24;
  localparam int ScaleMul   = int'((longint'(255) << ScaleShift) /
                              ((longint'(1) << (2 * LevelFracBits)) * HueSector));
  localparam int ScaleWidth = AccWidth + $clog2(ScaleMul + 1);

  localparam logic [AlphaWidth-1:0] AlphaReset = 8'hFF;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e                 sector;
    logic [TWidth-1:0]       tri_pos;
    logic [CnumWidth-1:0]    chroma;
    logic [LevelWidth-1:0]   lightness;
  } prep_t;

endpackage

// File: hw/rtl/hsl_to_argb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_argb_converter
// Converts one HSL pixel per transaction into a packed ARGB8888 word.
// ----------------------------------------------------------------------------
// The converter takes one pixel every clock cycle while no stage is held, and
// each result passes through the six register stages of the pipeline: hue
// wrap, sector decode, chroma product, chroma terms, channel offset and byte
// scaling. Each stage holds its item while the next one is full and cannot
// advance, so a stalled output fills the empty stages before the input stalls.
// The alpha byte is written through cfg_we_i and should only change while no
// pixel is in flight.
module hsl_to_argb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: hue[14:0], saturation[23:15], lightness[32:24], zero.
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: argb_word[31:0].
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import hsl2argb_pkg::*;

  logic [AlphaWidth-1:0] alpha_q;
  logic                  prep_valid;
  logic                  prep_ready;
  prep_t                 prep_data;
  logic [RgbWidth-1:0]   rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  hsl2argb_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_hue_i    (s_axis_tdata[14:0]),
    .in_sat_i    (s_axis_tdata[23:15]),
    .in_lit_i    (s_axis_tdata[32:24]),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_data_o  (prep_data)
  );

  hsl2argb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_data_i   (prep_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rgb_o   (rgb)
  );

  assign m_axis_tdata = {alpha_q, rgb};

endmodule

// File: hw/rtl/hsl2argb_prep.sv
// ----------------------------------------------------------------------------
// hsl2argb_prep
// Three pipeline stages: input clamp and hue wrap, sector and triangle
// position, chroma product.
// ----------------------------------------------------------------------------
module hsl2argb_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hsl2argb_pkg::HueWidth-1:0]   in_hue_i,
  input  logic [hsl2argb_pkg::LevelWidth-1:0] in_sat_i,
  input  logic [hsl2argb_pkg::LevelWidth-1:0] in_lit_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hsl2argb_pkg::prep_t                 out_data_o
);
  import hsl2argb_pkg::*;

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  logic [HueWidth-1:0]   s1_hue_q, s1_hue_d;
  logic [LevelWidth-1:0] s1_sat_q, s1_sat_d;
  logic [LevelWidth-1:0] s1_lit_q, s1_lit_d;

  sector_e               s2_sec_q, s2_sec_d;
  logic [TWidth-1:0]     s2_t_q, s2_t_d;
  logic [LevelWidth-1:0] s2_fold_q, s2_fold_d;
  logic [LevelWidth-1:0] s2_sat_q;
  logic [LevelWidth-1:0] s2_lit_q;

  prep_t                 s3_q, s3_d;

  logic [2:0]            sec_cnt;
  logic [TposWidth-1:0]  tpos;
  logic [LevelWidth:0]   two_l;
  logic [2*LevelWidth-1:0] chroma_full;

  assign s3_rdy     = ~s3_v_q | out_ready_i;
  assign s2_rdy     = ~s2_v_q | s3_rdy;
  assign s1_rdy     = ~s1_v_q | s2_rdy;
  assign in_ready_o = s1_rdy;

  always_comb begin
    s1_sat_d = (in_sat_i > LevelWidth'(LevelOne)) ? LevelWidth'(LevelOne) : in_sat_i;
    s1_lit_d = (in_lit_i > LevelWidth'(LevelOne)) ? LevelWidth'(LevelOne) : in_lit_i;
    s1_hue_d = (in_hue_i >= HueWidth'(HueFull)) ? in_hue_i - HueWidth'(HueFull) : in_hue_i;
  end

  always_comb begin
    sec_cnt = '0;
    for (int k = 1; k < 6; k++) begin
      sec_cnt = sec_cnt + 3'(s1_hue_q >= HueWidth'(k * HueSector));
    end
    s2_sec_d = sector_e'(sec_cnt);
    if (s1_hue_q >= HueWidth'(4 * HueSector)) begin
      tpos = TposWidth'(s1_hue_q - HueWidth'(4 * HueSector));
    end else if (s1_hue_q >= HueWidth'(2 * HueSector)) begin
      tpos = TposWidth'(s1_hue_q - HueWidth'(2 * HueSector));
    end else begin
      tpos = TposWidth'(s1_hue_q);
    end
    if (tpos < TposWidth'(HueSector)) begin
      s2_t_d = TWidth'(tpos);
    end else begin
      s2_t_d = TWidth'(TposWidth'(2 * HueSector) - tpos);
    end
    two_l = {s1_lit_q, 1'b0};
    if (s1_lit_q <= LevelWidth'(LevelOne / 2)) begin
      s2_fold_d = LevelWidth'(two_l);
    end else begin
      s2_fold_d = LevelWidth'((LevelWidth + 1)'(2 * LevelOne) - two_l);
    end
  end

  always_comb begin
    chroma_full      = s2_fold_q * s2_sat_q;
    s3_d.sector      = s2_sec_q;
    s3_d.tri_pos     = s2_t_q;
    s3_d.chroma      = chroma_full[CnumWidth-1:0];
    s3_d.lightness   = s2_lit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_hue_q <= s1_hue_d;
      s1_sat_q <= s1_sat_d;
      s1_lit_q <= s1_lit_d;
    end
    if (s2_rdy && s1_v_q) begin
      s2_sec_q  <= s2_sec_d;
      s2_t_q    <= s2_t_d;
      s2_fold_q <= s2_fold_d;
      s2_sat_q  <= s1_sat_q;
      s2_lit_q  <= s1_lit_q;
    end
    if (s3_rdy && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_data_o  = s3_q;

endmodule

// File: hw/rtl/hsl2argb_mix.sv
// ----------------------------------------------------------------------------
// hsl2argb_mix
// Three pipeline stages: chroma terms, channel selection with offset, and
// scaling to bytes with clamping into the output register.
// ----------------------------------------------------------------------------
module hsl2argb_mix (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hsl2argb_pkg::prep_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hsl2argb_pkg::RgbWidth-1:0] out_rgb_o
);
  import hsl2argb_pkg::*;

  localparam int LshWidth = LevelWidth + LevelFracBits + 1;

  logic s4_v_q, s5_v_q, s6_v_q;
  logic s4_rdy, s5_rdy, s6_rdy;

  logic [ProdWidth-1:0] s4_cx_q, s4_cx_d;
  logic [ProdWidth-1:0] s4_cc_q, s4_cc_d;
  logic [ProdWidth-1:0] s4_m_q, s4_m_d;
  sector_e              s4_sec_q;

  logic [AccWidth-1:0]  s5_acc_q [3];
  logic [AccWidth-1:0]  s5_acc_d [3];
  logic [ProdWidth-1:0] sel [3];

  logic [RgbWidth-1:0]  s6_rgb_q, s6_rgb_d;

  logic [CnumWidth+TWidth-1:0] cx_full;
  logic [LshWidth-1:0]         lsh;
  logic [LshWidth-1:0]         diff;
  logic [ScaleWidth-1:0]       scaled [3];
  logic [ScaleWidth-ScaleShift-1:0] whole [3];

  assign s6_rdy     = ~s6_v_q | out_ready_i;
  assign s5_rdy     = ~s5_v_q | s6_rdy;
  assign s4_rdy     = ~s4_v_q | s5_rdy;
  assign in_ready_o = s4_rdy;

  always_comb begin
    cx_full = in_data_i.chroma * in_data_i.tri_pos;
    s4_cx_d = cx_full[ProdWidth-1:0];
    s4_cc_d = ProdWidth'(in_data_i.chroma) * ProdWidth'(HueSector);
    lsh     = {in_data_i.lightness, (LevelFracBits + 1)'(0)};
    diff    = lsh - LshWidth'(in_data_i.chroma);
    s4_m_d  = ProdWidth'(diff) * ProdWidth'(MidBias);
  end

  // Index 2 is red, 1 is green, 0 is blue.
  always_comb begin
    unique case (s4_sec_q)
      SEC_RED_YEL: begin
        sel[2] = s4_cc_q; sel[1] = s4_cx_q; sel[0] = '0;
      end
      SEC_YEL_GRN: begin
        sel[2] = s4_cx_q; sel[1] = s4_cc_q; sel[0] = '0;
      end
      SEC_GRN_CYN: begin
        sel[2] = '0; sel[1] = s4_cc_q; sel[0] = s4_cx_q;
      end
      SEC_CYN_BLU: begin
        sel[2] = '0; sel[1] = s4_cx_q; sel[0] = s4_cc_q;
      end
      SEC_BLU_MAG: begin
        sel[2] = s4_cx_q; sel[1] = '0; sel[0] = s4_cc_q;
      end
      default: begin
        sel[2] = s4_cc_q; sel[1] = '0; sel[0] = s4_cx_q;
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      s5_acc_d[c] = AccWidth'(sel[c]) + AccWidth'(s4_m_q);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = ScaleWidth'(s5_acc_q[c]) * ScaleWidth'(ScaleMul);
      whole[c]  = scaled[c][ScaleWidth-1:ScaleShift];
      s6_rgb_d[c*8 +: 8] = (whole[c] > (ScaleWidth - ScaleShift)'(255)) ? 8'hFF
                                                                         : whole[c][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (s4_rdy) s4_v_q <= in_valid_i;
      if (s5_rdy) s5_v_q <= s4_v_q;
      if (s6_rdy) s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy && in_valid_i) begin
      s4_cx_q  <= s4_cx_d;
      s4_cc_q  <= s4_cc_d;
      s4_m_q   <= s4_m_d;
      s4_sec_q <= in_data_i.sector;
    end
    if (s5_rdy && s4_v_q) begin
      s5_acc_q <= s5_acc_d;
    end
    if (s6_rdy && s5_v_q) begin
      s6_rgb_q <= s6_rgb_d;
    end
  end

  assign out_valid_o = s6_v_q;
  assign out_rgb_o   = s6_rgb_q;

endmodule

// File: hw/rtl/hsl2argb_checker.sv
// ----------------------------------------------------------------------------
// hsl2argb_checker
// Port-level checks of the HSL to ARGB8888 converter, bound to its top level.
// ----------------------------------------------------------------------------
module hsl2argb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        cfg_we_i,
  input logic [7:0]  cfg_wdata_i
);

  // A stalled result keeps its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  // An empty output stage means the whole pipeline can advance.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is being taken");

  // The alpha byte only changes after a register write.
  a_alpha_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid) && !$past(cfg_we_i)
      |-> m_axis_tdata[31:24] == $past(m_axis_tdata[31:24]))
    else $error("alpha byte changed without a register write");

  a_alpha_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> m_axis_tdata[31:24] == $past(cfg_wdata_i))
    else $error("alpha byte does not match the written value");

endmodule

bind hsl_to_argb_converter hsl2argb_checker u_hsl2argb_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the HSL to ARGB8888 converter. Pixels are
// streamed in with random gaps and output stalls. A behavioral model computes
// the expected ARGB word for every accepted pixel from exact integer math over
// a common denominator, and the output stream is compared in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import hsl2argb_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0: hue[14:0], saturation[23:15], lightness[32:24], zero.
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0: argb_word[31:0].
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;

  logic [AlphaWidth-1:0] alpha_shadow = AlphaReset;
  logic [31:0]           argb_queue[$];
  logic [31:0]           argb_want;
  int                    mismatch_count = 0;
  int                    stall_left     = 0;
  int                    hold_req       = 0;
  int                    idle_cycles    = 0;
  bit                    no_gaps        = 1'b0;

  hsl_to_argb_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint channel_byte(input longint num, input longint den);
    longint v;
    if (num <= 0) return 0;
    v = (num * 255) / den;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic logic [31:0] hsl_to_argb(input logic [HueWidth-1:0] hue,
                                              input logic [LevelWidth-1:0] sat,
                                              input logic [LevelWidth-1:0] lgt,
                                              input logic [AlphaWidth-1:0] alpha);
    longint  h, s, l, tpos, cnum, xnum, den, cd, xd, md, rp, gp, bp, r, g, b;
    sector_e sec;
    h = longint'(hue) % HueFull;
    s = (sat > LevelOne) ? LevelOne : longint'(sat);
    l = (lgt > LevelOne) ? LevelOne : longint'(lgt);
    sec  = sector_e'(h / HueSector);
    tpos = h % (2 * HueSector);
    cnum = (LevelOne - ((2 * l >= LevelOne) ? 2 * l - LevelOne : LevelOne - 2 * l)) * s;
    xnum = cnum * (HueSector - ((tpos >= HueSector) ? tpos - HueSector : HueSector - tpos));
    den  = 2 * longint'(LevelOne) * LevelOne * HueSector;
    cd   = cnum * 2 * HueSector;
    xd   = xnum * 2;
    md   = l * LevelOne * 2 * HueSector - cnum * HueSector;
    case (sec)
      SEC_RED_YEL: begin rp = cd; gp = xd; bp = 0;  end
      SEC_YEL_GRN: begin rp = xd; gp = cd; bp = 0;  end
      SEC_GRN_CYN: begin rp = 0;  gp = cd; bp = xd; end
      SEC_CYN_BLU: begin rp = 0;  gp = xd; bp = cd; end
      SEC_BLU_MAG: begin rp = xd; gp = 0;  bp = cd; end
      default:     begin rp = cd; gp = 0;  bp = xd; end
    endcase
    r = channel_byte(rp + md, den);
    g = channel_byte(gp + md, den);
    b = channel_byte(bp + md, den);
    return {alpha, r[7:0], g[7:0], b[7:0]};
  endfunction

  task automatic note_mismatch(input logic [31:0] want, input logic [31:0] got,
                               input bit unexpected);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (unexpected) $display("tb_top: unexpected result %h", got);
      else $display("tb_top: mismatch expected %h actual %h", want, got);
    end
  endtask

  // Compare each output transaction first, then predict from each input one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (argb_queue.size() == 0) begin
        note_mismatch('0, m_axis_tdata, 1'b1);
      end else begin
        argb_want = argb_queue.pop_front();
        if (m_axis_tdata !== argb_want) note_mismatch(argb_want, m_axis_tdata, 1'b0);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      argb_queue.push_back(hsl_to_argb(s_axis_tdata[14:0], s_axis_tdata[23:15],
                                       s_axis_tdata[32:24], alpha_shadow));
    end
  end

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input int hue, input int sat, input int lgt);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, LevelWidth'(lgt), LevelWidth'(sat), HueWidth'(hue)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_pixel();
    int r, hv;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_pixel($urandom_range(0, HueFull), $urandom_range(0, LevelOne),
                 $urandom_range(0, LevelOne));
    end else if (r < 85) begin
      send_pixel($urandom_range(0, 32767), $urandom_range(0, 511), $urandom_range(0, 511));
    end else begin
      hv = $urandom_range(0, 6) * HueSector + $urandom_range(0, 4) - 2;
      if (hv < 0) hv = 0;
      send_pixel(hv, $urandom_range(0, 1) ? LevelOne : $urandom_range(0, LevelOne),
                 $urandom_range(0, LevelOne));
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (argb_queue.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_alpha(input logic [AlphaWidth-1:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    alpha_shadow = value;
  endtask

  task automatic test_directed_corners();
    int k;
    send_pixel(0, 0, 0);
    send_pixel(0, LevelOne, LevelOne / 2);
    send_pixel(0, LevelOne, LevelOne);
    send_pixel(0, LevelOne, 0);
    send_pixel(HueFull, LevelOne, LevelOne / 2);
    send_pixel(HueFull - 1, LevelOne, LevelOne / 2);
    send_pixel(HueFull + 1, LevelOne, LevelOne / 2);
    send_pixel('h7fff, 'h1ff, 'h1ff);
    send_pixel('h7fff, LevelOne, LevelOne / 2);
    send_pixel(1000, 300, 100);
    send_pixel(5000, 120, 400);
    for (k = 1; k < 6; k++) begin
      send_pixel(k * HueSector, LevelOne, LevelOne / 2);
      send_pixel(k * HueSector + HueSector / 2, 200, 90);
    end
    send_pixel(HueSector / 2, 1, 1);
    send_pixel(3 * HueSector / 2, LevelOne, LevelOne - 1);
    send_pixel(12345, 'h155, 'h0aa);
  endtask

  task automatic test_alpha_extremes();
    int n;
    set_alpha(8'h00);
    for (n = 0; n < 15; n++) send_random_pixel();
    set_alpha(8'hff);
    for (n = 0; n < 15; n++) send_random_pixel();
    set_alpha(8'h5a);
    for (n = 0; n < 15; n++) send_random_pixel();
  endtask

  task automatic test_random_stream();
    int phase, n;
    for (phase = 0; phase < 4; phase++) begin
      set_alpha($urandom_range(0, 255));
      for (n = 0; n < 170; n++) send_random_pixel();
    end
  endtask

  task automatic test_back_to_back();
    int n;
    wait_drain();
    no_gaps = 1'b1;
    for (n = 0; n < 60; n++) send_random_pixel();
    no_gaps = 1'b0;
  endtask

  task automatic test_output_holdoff();
    int n;
    wait_drain();
    no_gaps  = 1'b1;
    hold_req = HoldCycles;
    for (n = 0; n < 40; n++) send_random_pixel();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_alpha_extremes();
    test_random_stream();
    test_back_to_back();
    test_output_holdoff();
    wait_drain();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
